@@ rtl/crc16_command_frame_builder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the command frame builder
// Shared helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef CRC16_COMMAND_FRAME_BUILDER_MACROS_SVH
`define CRC16_COMMAND_FRAME_BUILDER_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define CFB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cfb check failed");

// Check a property on every rising edge, reset included.
`define CFB_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("cfb check failed");

`endif

@@ rtl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg
// Constants, types and the CRC byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int MAX_FRAME_BYTES = 255;
	localparam int FRAME_OVERHEAD  = 8;

	// longest data run a start may ask for
	localparam logic [7:0] LEN_LIMIT  = 8'(MAX_FRAME_BYTES - FRAME_OVERHEAD);
	// count byte = data length + this
	localparam logic [7:0] COUNT_BIAS = 8'(FRAME_OVERHEAD - 1);

	localparam logic [15:0] CRC_POLY      = 16'h8005;
	localparam logic [7:0]  WORD_ADDR_CMD = 8'h03;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_START  = 2'd0;
	localparam kind_t KIND_DATA   = 2'd1;
	localparam kind_t KIND_REJECT = 2'd2;

	// byte selects of the output sequencer
	typedef logic [3:0] sel_t;
	localparam sel_t SEL_ADDR   = 4'd0;
	localparam sel_t SEL_COUNT  = 4'd1;
	localparam sel_t SEL_OPCODE = 4'd2;
	localparam sel_t SEL_P1     = 4'd3;
	localparam sel_t SEL_P2_LO  = 4'd4;
	localparam sel_t SEL_P2_HI  = 4'd5;
	localparam sel_t SEL_CRC_LO = 4'd6;
	localparam sel_t SEL_CRC_HI = 4'd7;
	localparam sel_t SEL_DATA   = 4'd8;
	localparam sel_t SEL_REJECT = 4'd9;

	// sequencer step counts
	typedef logic [2:0] step_t;
	localparam step_t STEP_HDR_END  = 3'd5;
	localparam step_t STEP_FULL_END = 3'd7;
	localparam step_t STEP_DATA     = 3'd0;
	localparam step_t STEP_DCRC_LO  = 3'd1;
	localparam step_t STEP_DCRC_HI  = 3'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		kind_t       kind;
		logic        tail;         // append the CRC trailer after this word
		logic [7:0]  opcode;
		logic [7:0]  first_param;
		logic [15:0] second_param;
		logic [7:0]  count;
		logic [7:0]  data_byte;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (b[i] != c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/cfb_fifo.sv @@
// ----------------------------------------------------------------------------
// cfb_fifo
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module cfb_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cfb_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output cfb_pkg::cmd_t       head,
	output cfb_pkg::fifo_stat_t stat
);

	cfb_pkg::cmd_t                  mem_q [cfb_pkg::FIFO_DEPTH];
	logic [cfb_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [cfb_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [cfb_pkg::FIFO_AW:0]      count_q;

	assign stat.full  = (count_q == (cfb_pkg::FIFO_AW+1)'(cfb_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/cfb_front.sv @@
// ----------------------------------------------------------------------------
// cfb_front
// Accept input words, track the open frame and queue one command per word.
// ----------------------------------------------------------------------------
module cfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [7:0]          opcode,
	input  logic [7:0]          first_param,
	input  logic [15:0]         second_param,
	input  logic [7:0]          data_length,
	input  logic [7:0]          data_byte,
	input  cfb_pkg::fifo_stat_t stat,
	output logic                push,
	output cfb_pkg::cmd_t       cmd
);

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic       open_d;
	logic [7:0] left_d;

	assign in_ready = !stat.full;
	assign push     = in_valid && !stat.full;

	always_comb begin
		cmd.kind         = cfb_pkg::KIND_REJECT;
		cmd.tail         = 1'b0;
		cmd.opcode       = opcode;
		cmd.first_param  = first_param;
		cmd.second_param = second_param;
		cmd.count        = data_length + cfb_pkg::COUNT_BIAS;
		cmd.data_byte    = data_byte;
		open_d           = frame_open_q;
		left_d           = bytes_left_q;
		if (mode == cfb_pkg::MODE_START) begin
			// a start always drops whatever frame was open
			open_d = 1'b0;
			left_d = '0;
			if (data_length <= cfb_pkg::LEN_LIMIT) begin
				cmd.kind = cfb_pkg::KIND_START;
				cmd.tail = (data_length == '0);
				open_d   = (data_length != '0);
				left_d   = data_length;
			end
		end else if (frame_open_q && bytes_left_q != '0) begin
			cmd.kind = cfb_pkg::KIND_DATA;
			cmd.tail = (bytes_left_q == 8'd1);
			left_d   = bytes_left_q - 8'd1;
			open_d   = (bytes_left_q != 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (push) begin
			frame_open_q <= open_d;
			bytes_left_q <= left_d;
		end
	end

endmodule

@@ rtl/cfb_back.sv @@
// ----------------------------------------------------------------------------
// cfb_back
// Expand queued commands into frame bytes, run the CRC and hold the output.
// ----------------------------------------------------------------------------
module cfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cfb_pkg::cmd_t       head,
	input  cfb_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                frame_last,
	output logic                rejected
);

	logic           out_valid_q;
	logic [7:0]     byte_q;
	logic           last_q;
	logic           rej_q;
	cfb_pkg::step_t step_q;
	logic [15:0]    crc_q;

	logic           adv;
	logic           go;
	cfb_pkg::sel_t  sel;
	logic           last_step;
	logic [7:0]     byte_d;

	assign adv = !out_valid_q || out_ready;
	assign go  = adv && !stat.empty;
	assign pop = go && last_step;

	always_comb begin
		sel       = cfb_pkg::SEL_REJECT;
		last_step = 1'b1;
		case (head.kind)
			cfb_pkg::KIND_START: begin
				sel       = cfb_pkg::sel_t'(step_q);
				last_step = (step_q == (head.tail ? cfb_pkg::STEP_FULL_END
				                                  : cfb_pkg::STEP_HDR_END));
			end
			cfb_pkg::KIND_DATA: begin
				case (step_q)
					cfb_pkg::STEP_DATA:    sel = cfb_pkg::SEL_DATA;
					cfb_pkg::STEP_DCRC_LO: sel = cfb_pkg::SEL_CRC_LO;
					default:               sel = cfb_pkg::SEL_CRC_HI;
				endcase
				last_step = (step_q == (head.tail ? cfb_pkg::STEP_DCRC_HI
				                                  : cfb_pkg::STEP_DATA));
			end
			default: begin
				sel       = cfb_pkg::SEL_REJECT;
				last_step = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (sel)
			cfb_pkg::SEL_ADDR:   byte_d = cfb_pkg::WORD_ADDR_CMD;
			cfb_pkg::SEL_COUNT:  byte_d = head.count;
			cfb_pkg::SEL_OPCODE: byte_d = head.opcode;
			cfb_pkg::SEL_P1:     byte_d = head.first_param;
			cfb_pkg::SEL_P2_LO:  byte_d = head.second_param[7:0];
			cfb_pkg::SEL_P2_HI:  byte_d = head.second_param[15:8];
			cfb_pkg::SEL_CRC_LO: byte_d = crc_q[7:0];
			cfb_pkg::SEL_CRC_HI: byte_d = crc_q[15:8];
			cfb_pkg::SEL_DATA:   byte_d = head.data_byte;
			default:             byte_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
			crc_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= !stat.empty;
			end
			if (go) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
				case (sel)
					cfb_pkg::SEL_ADDR: crc_q <= '0;
					cfb_pkg::SEL_COUNT, cfb_pkg::SEL_OPCODE, cfb_pkg::SEL_P1,
					cfb_pkg::SEL_P2_LO, cfb_pkg::SEL_P2_HI, cfb_pkg::SEL_DATA:
						crc_q <= cfb_pkg::crc_byte(crc_q, byte_d);
					default: crc_q <= crc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q <= byte_d;
			last_q <= (sel == cfb_pkg::SEL_CRC_HI);
			rej_q  <= (sel == cfb_pkg::SEL_REJECT);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign frame_last = last_q;
	assign rejected   = rej_q;

endmodule

@@ rtl/crc16_command_frame_builder.sv @@
// ----------------------------------------------------------------------------
// crc16_command_frame_builder
// Command frame builder with a CRC-16 (poly 0x8005) trailer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per command item. tuser = mode: 0 starts a frame
//   (opcode, first_param, second_param, data_length), 1 carries one data byte.
//   m_axis carries the frame one byte per word; tlast marks the CRC high byte
//   that ends a frame and tuser flags a rejected word (data byte 0).
//   A start emits 0x03, count, opcode, first_param, second_param low/high;
//   with length 0 the CRC low/high bytes follow at once. Each data word
//   gives its byte, and the last one is followed by the CRC trailer.
// Path: an accepted word is queued; its bytes are registered from the queue.
// Throughput: the output sequencer emits one byte per cycle unless stalled;
//   a data word gives one byte (the last adds the CRC trailer), a start
//   six, eight with length 0. A four-entry queue between the classifier and
//   the sequencer absorbs header bursts; s_axis_tready drops when it fills.
// Reset: arst_n clears the open frame, the CRC, the queue and the output.
// Stall: with m_axis_tready low the output word holds, the queue fills and
//   then s_axis_tready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module crc16_command_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] opcode, [15:8] first_param, [31:16] second_param,
	// [39:32] data_length, [47:40] data_byte
	input  logic [47:0] s_axis_tdata,
	// [0] mode
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	// [0] rejected
	output logic [0:0]  m_axis_tuser
);

	cfb_pkg::cmd_t       push_cmd;
	cfb_pkg::cmd_t       head;
	cfb_pkg::fifo_stat_t stat;
	logic                push;
	logic                pop;

	// classify words and keep the frame bookkeeping
	cfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (s_axis_tuser[0]),
		.opcode       (s_axis_tdata[7:0]),
		.first_param  (s_axis_tdata[15:8]),
		.second_param (s_axis_tdata[31:16]),
		.data_length  (s_axis_tdata[39:32]),
		.data_byte    (s_axis_tdata[47:40]),
		.stat         (stat),
		.push         (push),
		.cmd          (push_cmd)
	);

	// decouple the two sides
	cfb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// expand commands into bytes and append the CRC
	cfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.stat       (stat),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.frame_last (m_axis_tlast),
		.rejected   (m_axis_tuser[0])
	);

endmodule

@@ rtl/cfb_checker.sv @@
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc16_command_frame_builder_macros.svh"

module cfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	// hold a stalled output word
	`CFB_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

	// a rejected word is a lone zero byte, never a frame end
	`CFB_ASSERT(a_reject_form, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && !m_axis_tlast)

	// input backpressure only while output work is pending
	`CFB_ASSERT(a_stall_cause, clk, arst_n, !s_axis_tready |-> m_axis_tvalid)

	// no output word once a reset edge has been seen
	`CFB_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_axis_tvalid)

endmodule

bind crc16_command_frame_builder cfb_checker u_cfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: command frame builder bench
// Streams start and data words into the frame builder and checks every output
// byte, end-of-frame mark and reject flag against a CRC-16 frame predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import cfb_pkg::*;

	localparam int ITEMS_TOTAL  = 170;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT_WORD = 60;
	localparam int TAIL_CYCLES  = 20;

	// one command word as queued for the driver
	typedef struct packed {
		logic        mode;
		logic [7:0]  opcode;
		logic [7:0]  first_param;
		logic [15:0] second_param;
		logic [7:0]  data_length;
		logic [7:0]  data_byte;
		logic        drain;        // wait until all output bytes are back first
	} cmd_item_t;

	// one output byte as predicted
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       rej;
	} frame_word_t;

	// receiver stall styles, chosen by cycle count
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_SLOW} rx_style_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] opcode, [15:8] first_param, [31:16] second_param,
	// [39:32] data_length, [47:40] data_byte
	logic [47:0] s_axis_tdata  = '0;
	// [0] mode
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] out_byte
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	// [0] rejected
	logic [0:0]  m_axis_tuser;

	crc16_command_frame_builder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pending command words and predicted frame bytes
	cmd_item_t   pending_q[$];
	frame_word_t frame_bytes_q[$];

	// predictor state
	logic [15:0] run_crc      = '0;
	logic [7:0]  data_left    = '0;
	logic        frame_active = 1'b0;

	int errors      = 0;
	int words_in    = 0;
	int starts_in   = 0;
	int data_in     = 0;
	int bytes_out   = 0;
	int frames_done = 0;
	int rejects_out = 0;

	// CRC-16, poly 0x8005, data bits LSB first into an MSB-first register
	function automatic logic [15:0] crc16_shift_byte(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = b[i] ^ c[15];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void add_word(input logic [7:0] v, input logic l, input logic r);
		frame_word_t w;
		w.value = v;
		w.last  = l;
		w.rej   = r;
		frame_bytes_q.push_back(w);
	endfunction

	function automatic void add_crc_trailer();
		add_word(run_crc[7:0], 1'b0, 1'b0);
		add_word(run_crc[15:8], 1'b1, 1'b0);
	endfunction

	// predict the output bytes that one accepted command word causes
	function automatic void build_frame(input cmd_item_t it);
		logic [7:0] hdr[5];
		if (it.mode == MODE_START) begin
			// a start always closes whatever frame was open
			frame_active = 1'b0;
			data_left    = '0;
			if (it.data_length > LEN_LIMIT) begin
				add_word(8'h00, 1'b0, 1'b1);
			end else begin
				hdr[0] = it.data_length + COUNT_BIAS;
				hdr[1] = it.opcode;
				hdr[2] = it.first_param;
				hdr[3] = it.second_param[7:0];
				hdr[4] = it.second_param[15:8];
				add_word(WORD_ADDR_CMD, 1'b0, 1'b0);
				run_crc = '0;
				for (int i = 0; i < 5; i++) begin
					add_word(hdr[i], 1'b0, 1'b0);
					run_crc = crc16_shift_byte(run_crc, hdr[i]);
				end
				if (it.data_length == 8'd0) begin
					add_crc_trailer();
				end else begin
					data_left    = it.data_length;
					frame_active = 1'b1;
				end
			end
		end else if (!frame_active || data_left == 8'd0) begin
			add_word(8'h00, 1'b0, 1'b1);
		end else begin
			add_word(it.data_byte, 1'b0, 1'b0);
			run_crc   = crc16_shift_byte(run_crc, it.data_byte);
			data_left = data_left - 8'd1;
			if (data_left == 8'd0) begin
				add_crc_trailer();
				frame_active = 1'b0;
			end
		end
	endfunction

	// unused fields get random values so that the block must ignore them
	function automatic cmd_item_t start_cmd(input logic [7:0] op, input logic [7:0] p1,
			input logic [15:0] p2, input logic [7:0] len, input logic drain);
		cmd_item_t it;
		it.mode         = MODE_START;
		it.opcode       = op;
		it.first_param  = p1;
		it.second_param = p2;
		it.data_length  = len;
		it.data_byte    = 8'($urandom);
		it.drain        = drain;
		return it;
	endfunction

	function automatic cmd_item_t data_cmd(input logic [7:0] b);
		cmd_item_t it;
		it.mode         = MODE_DATA;
		it.opcode       = 8'($urandom);
		it.first_param  = 8'($urandom);
		it.second_param = 16'($urandom);
		it.data_length  = 8'($urandom);
		it.data_byte    = b;
		it.drain        = 1'b0;
		return it;
	endfunction

	function automatic cmd_item_t rand_start(input logic [7:0] len, input logic drain);
		return start_cmd(8'($urandom), 8'($urandom), 16'($urandom), len, drain);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer queued words in bursts, hold tvalid until accepted
	// ------------------------------------------------------------------------
	cmd_item_t cur_cmd    = '0;
	logic      offer;
	int        burst_left = 4;
	int        gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				build_frame(cur_cmd);
				words_in++;
				if (cur_cmd.mode == MODE_START)
					starts_in++;
				else
					data_in++;
				offer = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					                                         : $urandom_range(1, 8);
				end
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0 &&
						!(pending_q[0].drain && frame_bytes_q.size() != 0)) begin
					cur_cmd = pending_q.pop_front();
					offer   = 1'b1;
				end
			end
			s_axis_tvalid <= offer;
			s_axis_tuser  <= cur_cmd.mode;
			s_axis_tdata  <= {cur_cmd.data_byte, cur_cmd.data_length, cur_cmd.second_param,
			                  cur_cmd.first_param, cur_cmd.opcode};
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each output word, stall on a cycle-based pattern
	// ------------------------------------------------------------------------
	frame_word_t mon_word;
	logic        rx_ready;
	int          cyc_cnt        = 0;
	int          long_hold_left = 0;
	logic        long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				bytes_out++;
				if (m_axis_tlast)
					frames_done++;
				if (m_axis_tuser[0])
					rejects_out++;
				if (frame_bytes_q.size() == 0) begin
					$error("unexpected output word: out_byte %02h tlast %0b rejected %0b",
					       m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
					errors++;
				end else begin
					mon_word = frame_bytes_q.pop_front();
					if (m_axis_tdata !== mon_word.value) begin
						$error("out_byte mismatch: expected %02h, actual %02h",
						       mon_word.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== mon_word.last) begin
						$error("frame_last mismatch: expected %0b, actual %0b",
						       mon_word.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser[0] !== mon_word.rej) begin
						$error("rejected mismatch: expected %0b, actual %0b",
						       mon_word.rej, m_axis_tuser[0]);
						errors++;
					end
				end
			end

			cyc_cnt++;
			// hold off once for a long stretch so the command queue fills
			if (!long_hold_done && words_in >= HOLD_AT_WORD) begin
				long_hold_left = HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				rx_ready = 1'b0;
			end else begin
				case (rx_style_t'(cyc_cnt[8:7]))
					RX_FREE:  rx_ready = 1'b1;
					RX_LIGHT: rx_ready = ($urandom_range(0, 3) != 0);
					RX_HEAVY: rx_ready = ($urandom_range(0, 2) == 0);
					default:  rx_ready = cyc_cnt[2];
				endcase
			end
			m_axis_tready <= rx_ready;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		int   len;
		int   cut;
		int   pick;
		int   r;
		logic mid_drain_done;
		mid_drain_done = 1'b0;

		// directed part
		pending_q.push_back(data_cmd(8'hFF));                          // no frame open
		pending_q.push_back(start_cmd(8'hFF, 8'h00, 16'hFFFF, 8'd0, 1'b0)); // zero length
		pending_q.push_back(start_cmd(8'h00, 8'hFF, 16'h0000, 8'd0, 1'b0));
		pending_q.push_back(start_cmd(8'hA5, 8'h5A, 16'h1234, 8'd1, 1'b0));
		pending_q.push_back(data_cmd(8'h00));
		pending_q.push_back(data_cmd(8'hAA));                          // frame already closed
		pending_q.push_back(start_cmd(8'h01, 8'h80, 16'h8001, 8'd2, 1'b0));
		pending_q.push_back(data_cmd(8'hFF));
		pending_q.push_back(data_cmd(8'h80));
		pending_q.push_back(start_cmd(8'h7F, 8'hFE, 16'h00FF, LEN_LIMIT, 1'b0)); // longest
		pending_q.push_back(data_cmd(8'h01));
		pending_q.push_back(data_cmd(8'hFE));
		pending_q.push_back(data_cmd(8'h7F));
		pending_q.push_back(start_cmd(8'h3C, 8'hC3, 16'hFF00, 8'd2, 1'b0)); // abandon frame
		pending_q.push_back(data_cmd(8'h55));
		pending_q.push_back(data_cmd(8'h01));
		pending_q.push_back(start_cmd(8'h12, 8'h34, 16'h5678, 8'd255, 1'b0)); // too long
		pending_q.push_back(start_cmd(8'h9A, 8'hBC, 16'hDEF0, LEN_LIMIT + 8'd1, 1'b0));
		pending_q.push_back(start_cmd(8'h0F, 8'hF0, 16'hAAAA, 8'd3, 1'b0));
		pending_q.push_back(data_cmd(8'h33));
		pending_q.push_back(start_cmd(8'hE1, 8'h1E, 16'h5555, LEN_LIMIT + 8'd1, 1'b0));
		pending_q.push_back(data_cmd(8'hCC));                          // reject closed it
		pending_q.push_back(start_cmd(8'h44, 8'h88, 16'h0102, 8'd0, 1'b1));

		// random part: mostly whole frames, some broken ones and noise
		while (pending_q.size() < ITEMS_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				pending_q.push_back(data_cmd(8'($urandom)));
			end else if (pick < 16) begin
				pending_q.push_back(rand_start(8'($urandom_range(248, 255)), 1'b0));
			end else begin
				r = $urandom_range(0, 19);
				if (r < 3)
					len = 0;
				else if (r < 17)
					len = $urandom_range(1, 6);
				else if (r < 19)
					len = $urandom_range(7, 24);
				else
					len = $urandom_range(25, 60);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
				pending_q.push_back(rand_start(8'(len),
				                               pending_q.size() >= 110 && !mid_drain_done));
				if (pending_q.size() > 110)
					mid_drain_done = 1'b1;
				for (int j = 0; j < cut; j++)
					pending_q.push_back(data_cmd(8'($urandom)));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain stimulus, then outstanding bytes, then a short tail
		while (pending_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (frame_bytes_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d command words (%0d starts, %0d data bytes).",
		         words_in, starts_in, data_in);
		$display("Checked %0d output bytes: %0d complete frames, %0d rejections.",
		         bytes_out, frames_done, rejects_out);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
